### rtl/cpu8080_arith_unit_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef CPU8080_ARITH_UNIT_MACROS_SVH
`define CPU8080_ARITH_UNIT_MACROS_SVH

// Check a consequence in the same cycle as the antecedent.
`define C80AU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define C80AU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/c80au_pkg.sv
package c80au_pkg;

  localparam int unsigned FLAG_CY = 0;
  localparam int unsigned FLAG_P  = 1;
  localparam int unsigned FLAG_Z  = 2;
  localparam int unsigned FLAG_S  = 3;

  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [2:0] LO_INR = 3'd4;
  localparam logic [2:0] LO_DCR = 3'd5;
  localparam logic [3:0] LO_INX = 4'h3;
  localparam logic [3:0] LO_DCX = 4'hb;
  localparam logic [3:0] LO_DAD = 4'h9;
  localparam logic [2:0] GRP_ALU = 3'b100;

  localparam logic [7:0] OP_ADI = 8'hc6;
  localparam logic [7:0] OP_ACI = 8'hce;
  localparam logic [7:0] OP_SUI = 8'hd6;
  localparam logic [7:0] OP_SBI = 8'hde;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_ADC = 2'd1,
    ALU_SUB = 2'd2,
    ALU_SBB = 2'd3
  } alu_kind_e;

  typedef struct packed {
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [7:0]  a;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
  } arch_t;

  typedef struct packed {
    arch_t      st;
    logic       mem_write;
    logic [7:0] mem_data;
    logic       status;
  } res_t;

endpackage

### rtl/cpu8080_arith_unit.sv
// Channel  Handshake                 Beat payload
// in       in_valid_i / in_ready_o   opcode_i, immediate_i, mem_operand_i
// out      out_valid_o / out_ready_i acc_out_o .. pc_out_o, flags_out_o,
//                                    mem_write_o, mem_data_o, status_o
//
// An accepted input beat waits in the input register, then executes into the
// result register, which offers it. Throughput: one instruction per cycle
// while the output is not stalled; the 8/16-bit execute adds bound the cycle.
// Reset clears all registers, pairs, SP, PC and flags to zero.
// A stalled output holds its beat; the input register holds one more beat.
`include "cpu8080_arith_unit_macros.svh"

module cpu8080_arith_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  immediate_i,
  input  logic [7:0]  mem_operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  acc_out_o,
  output logic [15:0] bc_out_o,
  output logic [15:0] de_out_o,
  output logic [15:0] hl_out_o,
  output logic [15:0] sp_out_o,
  output logic [15:0] pc_out_o,
  output logic [3:0]  flags_out_o,
  output logic        mem_write_o,
  output logic [7:0]  mem_data_o,
  output logic        status_o
);

  logic            in_valid_q;
  logic [7:0]      opcode_q;
  logic [7:0]      immediate_q;
  logic [7:0]      mem_operand_q;
  logic            out_valid_q;
  logic            advance;
  c80au_pkg::res_t res_d;
  c80au_pkg::res_t res_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      opcode_q      <= opcode_i;
      immediate_q   <= immediate_i;
      mem_operand_q <= mem_operand_i;
    end
  end

  c80au_exec u_exec (
    .state_i       (res_q.st),
    .opcode_i      (opcode_q),
    .immediate_i   (immediate_q),
    .mem_operand_i (mem_operand_q),
    .result_o      (res_d)
  );

  // The result register doubles as the architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        res_q <= res_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign acc_out_o   = res_q.st.a;
  assign bc_out_o    = {res_q.st.b, res_q.st.c};
  assign de_out_o    = {res_q.st.d, res_q.st.e};
  assign hl_out_o    = {res_q.st.h, res_q.st.l};
  assign sp_out_o    = res_q.st.sp;
  assign pc_out_o    = res_q.st.pc;
  assign flags_out_o = res_q.st.flags;
  assign mem_write_o = res_q.mem_write;
  assign mem_data_o  = res_q.mem_data;
  assign status_o    = res_q.status;

  `C80AU_ASSERT_NOW(a_bad_op_no_write, out_valid_q && res_q.status,
    !res_q.mem_write && (res_q.mem_data == 8'd0), "rejected opcode writes memory")
  `C80AU_ASSERT_NOW(a_quiet_data, out_valid_q && !res_q.mem_write,
    res_q.mem_data == 8'd0, "memory data without a write")
  `C80AU_ASSERT_NEXT(a_pc_step, advance,
    (res_q.st.pc == $past(res_q.st.pc)) || (res_q.st.pc == $past(res_q.st.pc) + 16'd1),
    "program counter moved by more than one")
  `C80AU_ASSERT_NEXT(a_result_follows, advance, out_valid_q, "executed beat lost")
  `C80AU_ASSERT_NEXT(a_input_held, in_valid_q && !advance, in_valid_q,
    "stalled input beat dropped")

endmodule

### rtl/c80au_exec.sv
module c80au_exec (
  input  c80au_pkg::arch_t state_i,
  input  logic [7:0]       opcode_i,
  input  logic [7:0]       immediate_i,
  input  logic [7:0]       mem_operand_i,
  output c80au_pkg::res_t  result_o
);

  function automatic logic [7:0] reg_rd(c80au_pkg::arch_t s, logic [2:0] idx,
                                        logic [7:0] m);
    logic [7:0] v;
    unique case (idx)
      c80au_pkg::REG_B: v = s.b;
      c80au_pkg::REG_C: v = s.c;
      c80au_pkg::REG_D: v = s.d;
      c80au_pkg::REG_E: v = s.e;
      c80au_pkg::REG_H: v = s.h;
      c80au_pkg::REG_L: v = s.l;
      c80au_pkg::REG_M: v = m;
      c80au_pkg::REG_A: v = s.a;
    endcase
    return v;
  endfunction

  function automatic c80au_pkg::arch_t reg_wr(c80au_pkg::arch_t s, logic [2:0] idx,
                                              logic [7:0] v);
    c80au_pkg::arch_t r;
    r = s;
    unique case (idx)
      c80au_pkg::REG_B: r.b = v;
      c80au_pkg::REG_C: r.c = v;
      c80au_pkg::REG_D: r.d = v;
      c80au_pkg::REG_E: r.e = v;
      c80au_pkg::REG_H: r.h = v;
      c80au_pkg::REG_L: r.l = v;
      c80au_pkg::REG_M: r = s;
      c80au_pkg::REG_A: r.a = v;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pair_rd(c80au_pkg::arch_t s, logic [1:0] idx);
    logic [15:0] v;
    unique case (idx)
      c80au_pkg::PAIR_BC: v = {s.b, s.c};
      c80au_pkg::PAIR_DE: v = {s.d, s.e};
      c80au_pkg::PAIR_HL: v = {s.h, s.l};
      c80au_pkg::PAIR_SP: v = s.sp;
    endcase
    return v;
  endfunction

  function automatic c80au_pkg::arch_t pair_wr(c80au_pkg::arch_t s, logic [1:0] idx,
                                               logic [15:0] v);
    c80au_pkg::arch_t r;
    r = s;
    unique case (idx)
      c80au_pkg::PAIR_BC: {r.b, r.c} = v;
      c80au_pkg::PAIR_DE: {r.d, r.e} = v;
      c80au_pkg::PAIR_HL: {r.h, r.l} = v;
      c80au_pkg::PAIR_SP: r.sp = v;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] zsp(logic [3:0] f, logic [7:0] v);
    logic [3:0] r;
    r = f;
    r[c80au_pkg::FLAG_P] = ~^v;
    r[c80au_pkg::FLAG_Z] = (v == 8'd0);
    r[c80au_pkg::FLAG_S] = v[7];
    return r;
  endfunction

  logic [2:0]           lo3;
  logic [2:0]           dst_idx;
  logic [1:0]           pair_idx;
  logic                 is_low;
  logic                 is_imm;
  logic                 is_alu;
  c80au_pkg::alu_kind_e kind;
  logic [7:0]           term;
  logic                 cin;
  logic [8:0]           alu_sum;
  logic [7:0]           step_val;
  logic [15:0]          pair_val;
  logic [16:0]          dad_sum;
  c80au_pkg::res_t      res;

  assign lo3      = opcode_i[2:0];
  assign dst_idx  = opcode_i[5:3];
  assign pair_idx = opcode_i[5:4];
  assign is_low   = (opcode_i[7:6] == 2'b00);
  assign is_alu   = (opcode_i[7:5] == c80au_pkg::GRP_ALU);
  assign is_imm   = (opcode_i == c80au_pkg::OP_ADI) || (opcode_i == c80au_pkg::OP_ACI) ||
                    (opcode_i == c80au_pkg::OP_SUI) || (opcode_i == c80au_pkg::OP_SBI);
  assign kind     = c80au_pkg::alu_kind_e'(opcode_i[4:3]);
  assign term     = is_imm ? immediate_i : reg_rd(state_i, lo3, mem_operand_i);
  assign cin      = ((kind == c80au_pkg::ALU_ADC) || (kind == c80au_pkg::ALU_SBB)) ?
                    state_i.flags[c80au_pkg::FLAG_CY] : 1'b0;

  always_comb begin
    case (kind) inside
      c80au_pkg::ALU_SUB,
      c80au_pkg::ALU_SBB: alu_sum = {1'b0, state_i.a} - {1'b0, term} - {8'd0, cin};
      default:            alu_sum = {1'b0, state_i.a} + {1'b0, term} + {8'd0, cin};
    endcase
  end

  assign step_val = (lo3 == c80au_pkg::LO_INR) ?
                    reg_rd(state_i, dst_idx, mem_operand_i) + 8'd1 :
                    reg_rd(state_i, dst_idx, mem_operand_i) - 8'd1;
  assign pair_val = pair_rd(state_i, pair_idx);
  assign dad_sum  = {1'b0, pair_rd(state_i, c80au_pkg::PAIR_HL)} + {1'b0, pair_val};

  always_comb begin
    res.st        = state_i;
    res.mem_write = 1'b0;
    res.mem_data  = 8'd0;
    res.status    = 1'b0;
    if (is_low && ((lo3 == c80au_pkg::LO_INR) || (lo3 == c80au_pkg::LO_DCR))) begin
      res.st       = reg_wr(state_i, dst_idx, step_val);
      res.st.flags = zsp(state_i.flags, step_val);
      if (dst_idx == c80au_pkg::REG_M) begin
        res.mem_write = 1'b1;
        res.mem_data  = step_val;
      end
    end else if (is_low && (opcode_i[3:0] == c80au_pkg::LO_INX)) begin
      res.st = pair_wr(state_i, pair_idx, pair_val + 16'd1);
    end else if (is_low && (opcode_i[3:0] == c80au_pkg::LO_DCX)) begin
      res.st = pair_wr(state_i, pair_idx, pair_val - 16'd1);
    end else if (is_low && (opcode_i[3:0] == c80au_pkg::LO_DAD)) begin
      res.st = pair_wr(state_i, c80au_pkg::PAIR_HL, dad_sum[15:0]);
      res.st.flags[c80au_pkg::FLAG_CY] = dad_sum[16];
    end else if (is_alu || is_imm) begin
      res.st.a     = alu_sum[7:0];
      res.st.flags = zsp(state_i.flags, alu_sum[7:0]);
      res.st.flags[c80au_pkg::FLAG_CY] = alu_sum[8];
      if (is_imm) begin
        res.st.pc = state_i.pc + 16'd1;
      end
    end else begin
      res.status = 1'b1;
    end
  end

  assign result_o = res;

endmodule

### verif/cpu8080_arith_checker.sv
`timescale 1ns / 1ps

module cpu8080_arith_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  immediate_i,
  input  logic [7:0]  mem_operand_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  acc_i,
  input  logic [15:0] bc_i,
  input  logic [15:0] de_i,
  input  logic [15:0] hl_i,
  input  logic [15:0] sp_i,
  input  logic [15:0] pc_i,
  input  logic [3:0]  flags_i,
  input  logic        mem_write_i,
  input  logic [7:0]  mem_data_i,
  input  logic        status_i,
  output int          fail_count_o,
  output int          pending_o
);

  c80au_pkg::arch_t cpu_state;
  c80au_pkg::res_t  expected_q[$];
  int               fails;
  logic             beat_bad;

  function automatic logic [3:0] zsp_flags(logic [3:0] flags, logic [7:0] v);
    logic [3:0] f;
    f                    = flags;
    f[c80au_pkg::FLAG_P] = ~^v;
    f[c80au_pkg::FLAG_Z] = (v == 8'h00);
    f[c80au_pkg::FLAG_S] = v[7];
    return f;
  endfunction

  function automatic logic [7:0] read_reg(c80au_pkg::arch_t s, logic [2:0] idx,
                                          logic [7:0] mem);
    case (idx)
      c80au_pkg::REG_B: return s.b;
      c80au_pkg::REG_C: return s.c;
      c80au_pkg::REG_D: return s.d;
      c80au_pkg::REG_E: return s.e;
      c80au_pkg::REG_H: return s.h;
      c80au_pkg::REG_L: return s.l;
      c80au_pkg::REG_M: return mem;
      default:          return s.a;
    endcase
  endfunction

  function automatic c80au_pkg::arch_t write_reg(c80au_pkg::arch_t s, logic [2:0] idx,
                                                 logic [7:0] v);
    case (idx)
      c80au_pkg::REG_B: s.b = v;
      c80au_pkg::REG_C: s.c = v;
      c80au_pkg::REG_D: s.d = v;
      c80au_pkg::REG_E: s.e = v;
      c80au_pkg::REG_H: s.h = v;
      c80au_pkg::REG_L: s.l = v;
      c80au_pkg::REG_M: ;
      default:          s.a = v;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] read_pair(c80au_pkg::arch_t s, logic [1:0] pr);
    case (pr)
      c80au_pkg::PAIR_BC: return {s.b, s.c};
      c80au_pkg::PAIR_DE: return {s.d, s.e};
      c80au_pkg::PAIR_HL: return {s.h, s.l};
      default:            return s.sp;
    endcase
  endfunction

  function automatic c80au_pkg::arch_t write_pair(c80au_pkg::arch_t s, logic [1:0] pr,
                                                  logic [15:0] v);
    case (pr)
      c80au_pkg::PAIR_BC: {s.b, s.c} = v;
      c80au_pkg::PAIR_DE: {s.d, s.e} = v;
      c80au_pkg::PAIR_HL: {s.h, s.l} = v;
      default:            s.sp = v;
    endcase
    return s;
  endfunction

  function automatic c80au_pkg::arch_t alu_exec(c80au_pkg::arch_t s,
                                                c80au_pkg::alu_kind_e kind,
                                                logic [7:0] term);
    logic [8:0] sum;
    logic       cin;
    cin = (kind == c80au_pkg::ALU_ADC || kind == c80au_pkg::ALU_SBB) ?
          s.flags[c80au_pkg::FLAG_CY] : 1'b0;
    if (kind == c80au_pkg::ALU_SUB || kind == c80au_pkg::ALU_SBB) begin
      sum = {1'b0, s.a} - {1'b0, term} - {8'h00, cin};
    end else begin
      sum = {1'b0, s.a} + {1'b0, term} + {8'h00, cin};
    end
    s.a                         = sum[7:0];
    s.flags[c80au_pkg::FLAG_CY] = sum[8];
    s.flags                     = zsp_flags(s.flags, s.a);
    return s;
  endfunction

  task automatic apply_instr(input logic [7:0] op, input logic [7:0] imm,
                             input logic [7:0] mem);
    c80au_pkg::arch_t s;
    c80au_pkg::res_t  r;
    logic [7:0]       v;
    logic [16:0]      wide;
    logic [2:0]       idx;
    logic [1:0]       pr;
    s           = cpu_state;
    r.mem_write = 1'b0;
    r.mem_data  = 8'h00;
    r.status    = 1'b0;
    idx         = op[5:3];
    pr          = op[5:4];
    if (op[7:6] == 2'b00 &&
        (op[2:0] == c80au_pkg::LO_INR || op[2:0] == c80au_pkg::LO_DCR)) begin
      v       = read_reg(s, idx, mem);
      v       = (op[2:0] == c80au_pkg::LO_INR) ? v + 8'd1 : v - 8'd1;
      s       = write_reg(s, idx, v);
      s.flags = zsp_flags(s.flags, v);
      if (idx == c80au_pkg::REG_M) begin
        r.mem_write = 1'b1;
        r.mem_data  = v;
      end
    end else if (op[7:6] == 2'b00 && op[3:0] == c80au_pkg::LO_INX) begin
      s = write_pair(s, pr, read_pair(s, pr) + 16'd1);
    end else if (op[7:6] == 2'b00 && op[3:0] == c80au_pkg::LO_DCX) begin
      s = write_pair(s, pr, read_pair(s, pr) - 16'd1);
    end else if (op[7:6] == 2'b00 && op[3:0] == c80au_pkg::LO_DAD) begin
      wide = {1'b0, read_pair(s, c80au_pkg::PAIR_HL)} + {1'b0, read_pair(s, pr)};
      s.flags[c80au_pkg::FLAG_CY] = wide[16];
      s = write_pair(s, c80au_pkg::PAIR_HL, wide[15:0]);
    end else if (op[7:5] == c80au_pkg::GRP_ALU) begin
      s = alu_exec(s, c80au_pkg::alu_kind_e'(op[4:3]), read_reg(s, op[2:0], mem));
    end else if (op == c80au_pkg::OP_ADI || op == c80au_pkg::OP_ACI ||
                 op == c80au_pkg::OP_SUI || op == c80au_pkg::OP_SBI) begin
      s    = alu_exec(s, c80au_pkg::alu_kind_e'(op[4:3]), imm);
      s.pc = s.pc + 16'd1;
    end else begin
      r.status = 1'b1;
    end
    cpu_state = s;
    r.st      = s;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp,
                               input logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      beat_bad = 1'b1;
    end
  endtask

  task automatic check_beat();
    c80au_pkg::res_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: result beat with no instruction outstanding", $time);
      fails++;
    end else begin
      exp      = expected_q.pop_front();
      beat_bad = 1'b0;
      compare_field("acc", {8'h00, exp.st.a}, {8'h00, acc_i});
      compare_field("bc", {exp.st.b, exp.st.c}, bc_i);
      compare_field("de", {exp.st.d, exp.st.e}, de_i);
      compare_field("hl", {exp.st.h, exp.st.l}, hl_i);
      compare_field("sp", exp.st.sp, sp_i);
      compare_field("pc", exp.st.pc, pc_i);
      compare_field("flags", {12'h000, exp.st.flags}, {12'h000, flags_i});
      compare_field("mem_write", {15'h0000, exp.mem_write}, {15'h0000, mem_write_i});
      compare_field("mem_data", {8'h00, exp.mem_data}, {8'h00, mem_data_i});
      compare_field("status", {15'h0000, exp.status}, {15'h0000, status_i});
      if (beat_bad) fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_state = '0;
      expected_q.delete();
      fails         = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) apply_instr(opcode_i, immediate_i, mem_operand_i);
      if (out_valid_i && out_ready_i) check_beat();
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int          CYCLE_LIMIT = 100000;
  localparam int          RANDOM_BEATS = 520;
  localparam int          CALM_BEATS = 60;
  localparam logic [7:0]  OP_NOP = 8'h00;
  localparam logic [7:0]  OP_HLT = 8'h76;
  localparam logic [7:0]  OP_RST7 = 8'hff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  opcode = 8'h00;
  logic [7:0]  immediate = 8'h00;
  logic [7:0]  mem_operand = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  acc_out;
  logic [15:0] bc_out;
  logic [15:0] de_out;
  logic [15:0] hl_out;
  logic [15:0] sp_out;
  logic [15:0] pc_out;
  logic [3:0]  flags_out;
  logic        mem_write;
  logic [7:0]  mem_data;
  logic        status;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  always #2 clk_i = ~clk_i;

  cpu8080_arith_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .immediate_i   (immediate),
    .mem_operand_i (mem_operand),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .acc_out_o     (acc_out),
    .bc_out_o      (bc_out),
    .de_out_o      (de_out),
    .hl_out_o      (hl_out),
    .sp_out_o      (sp_out),
    .pc_out_o      (pc_out),
    .flags_out_o   (flags_out),
    .mem_write_o   (mem_write),
    .mem_data_o    (mem_data),
    .status_o      (status)
  );

  cpu8080_arith_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .immediate_i   (immediate),
    .mem_operand_i (mem_operand),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .acc_i         (acc_out),
    .bc_i          (bc_out),
    .de_i          (de_out),
    .hl_i          (hl_out),
    .sp_i          (sp_out),
    .pc_i          (pc_out),
    .flags_i       (flags_out),
    .mem_write_i   (mem_write),
    .mem_data_i    (mem_data),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] op_step(logic [2:0] idx, logic [2:0] lo);
    return {2'b00, idx, lo};
  endfunction

  function automatic logic [7:0] op_pair(logic [1:0] pr, logic [3:0] lo);
    return {2'b00, pr, lo};
  endfunction

  function automatic logic [7:0] op_alu(c80au_pkg::alu_kind_e kind, logic [2:0] src);
    return {c80au_pkg::GRP_ALU, kind, src};
  endfunction

  function automatic logic [7:0] op_imm();
    case ($urandom_range(0, 3))
      0:       return c80au_pkg::OP_ADI;
      1:       return c80au_pkg::OP_ACI;
      2:       return c80au_pkg::OP_SUI;
      default: return c80au_pkg::OP_SBI;
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [3:0] lo;
    case ($urandom_range(0, 9))
      0, 1: return op_step(3'($urandom_range(0, 7)),
                           $urandom_range(0, 1) ? c80au_pkg::LO_INR : c80au_pkg::LO_DCR);
      2: begin
        case ($urandom_range(0, 2))
          0:       lo = c80au_pkg::LO_INX;
          1:       lo = c80au_pkg::LO_DCX;
          default: lo = c80au_pkg::LO_DAD;
        endcase
        return op_pair(2'($urandom_range(0, 3)), lo);
      end
      3, 4, 5, 6: return op_alu(c80au_pkg::alu_kind_e'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)));
      7:       return op_imm();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always begin
    @(posedge clk_i);
    if (rst_ni) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic [7:0] op, input logic [7:0] imm,
                           input logic [7:0] mem);
    in_valid    <= 1'b1;
    opcode      <= op;
    immediate   <= imm;
    mem_operand <= mem;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    send_beat(pick_opcode(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(op_step(c80au_pkg::REG_B, c80au_pkg::LO_INR), 8'h00, 8'h00);
    send_beat(op_step(c80au_pkg::REG_C, c80au_pkg::LO_DCR), 8'hff, 8'hff);
    send_beat(op_step(c80au_pkg::REG_M, c80au_pkg::LO_INR), 8'h00, 8'hff);
    send_beat(op_step(c80au_pkg::REG_M, c80au_pkg::LO_DCR), 8'hff, 8'h00);
    send_beat(op_step(c80au_pkg::REG_A, c80au_pkg::LO_INR), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_SP, c80au_pkg::LO_DCX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_SP, c80au_pkg::LO_INX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_SP, c80au_pkg::LO_DCX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_BC, c80au_pkg::LO_INX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_DE, c80au_pkg::LO_DCX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_HL, c80au_pkg::LO_DCX), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_SP, c80au_pkg::LO_DAD), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_HL, c80au_pkg::LO_DAD), 8'h00, 8'h00);
    send_beat(op_pair(c80au_pkg::PAIR_HL, c80au_pkg::LO_INX), 8'h00, 8'h00);
    send_beat(c80au_pkg::OP_ADI, 8'hff, 8'h00);
    send_beat(c80au_pkg::OP_ACI, 8'h00, 8'hff);
    send_beat(op_alu(c80au_pkg::ALU_ADD, c80au_pkg::REG_A), 8'h00, 8'h00);
    send_beat(op_alu(c80au_pkg::ALU_ADC, c80au_pkg::REG_M), 8'h00, 8'hff);
    send_beat(c80au_pkg::OP_SUI, 8'hff, 8'h00);
    send_beat(op_alu(c80au_pkg::ALU_SBB, c80au_pkg::REG_B), 8'h00, 8'h00);
    send_beat(c80au_pkg::OP_SBI, 8'h00, 8'h00);
    send_beat(op_alu(c80au_pkg::ALU_SUB, c80au_pkg::REG_A), 8'h00, 8'h00);
    send_beat(op_alu(c80au_pkg::ALU_SBB, c80au_pkg::REG_M), 8'h00, 8'hff);
    send_beat(OP_NOP, 8'hff, 8'hff);
    send_beat(OP_HLT, 8'h00, 8'h00);
    send_beat(OP_RST7, 8'hff, 8'hff);

    drain();
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) drain();
      send_random();
    end

    // back to back beats, no idling from here on
    calm = 1'b1;
    for (int i = 0; i < CALM_BEATS; i++) begin
      send_random();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
